>>> hdl/vfld_pkg.sv
// Shared types, constants and helpers for the vertex format layout decoder.
// No dependencies; the front end, queue, back end and top level import this package.
package vfld_pkg;

    localparam int MAX_TEX_SETS = 8;
    localparam int NUM_SLOTS    = 31;

    localparam logic [4:0] SLOT_FLAGS      = 5'd0;
    localparam logic [4:0] SLOT_TEX_SIZES  = 5'd1;
    localparam logic [4:0] SLOT_ELEM0      = 5'd2;
    localparam logic [4:0] SLOT_BLEND_OFF  = 5'd3;
    localparam logic [4:0] SLOT_BLEND_TYPE = 5'd4;
    localparam logic [4:0] SLOT_NORM_OFF   = 5'd5;
    localparam logic [4:0] SLOT_NORM_TYPE  = 5'd6;
    localparam logic [4:0] SLOT_DIFF_OFF   = 5'd7;
    localparam logic [4:0] SLOT_DIFF_TYPE  = 5'd8;
    localparam logic [4:0] SLOT_SPEC_OFF   = 5'd9;
    localparam logic [4:0] SLOT_SPEC_TYPE  = 5'd10;
    localparam logic [4:0] SLOT_ELEM5      = 5'd11;
    localparam logic [4:0] SLOT_ELEM6      = 5'd12;
    localparam logic [4:0] SLOT_ELEM7      = 5'd13;
    localparam logic [4:0] SLOT_ELEM8      = 5'd14;
    localparam logic [4:0] SLOT_TEX_FIRST  = 5'd15;
    localparam logic [4:0] SLOT_ELEM_LAST  = 5'd28;
    localparam logic [4:0] SLOT_TEX_LAST   = 5'd30;

    localparam logic [6:0] WORD_ELEM_LAST     = 7'd67;
    localparam logic [6:0] WORD_TEX_TYPE_LAST = 7'd71;

    localparam logic [6:0] SLOT_WORD [NUM_SLOTS] = '{
        7'd1,  7'd4,  7'd7,  7'd10, 7'd11, 7'd14, 7'd15, 7'd18,
        7'd19, 7'd22, 7'd23, 7'd27, 7'd31, 7'd35, 7'd39, 7'd42,
        7'd43, 7'd46, 7'd47, 7'd50, 7'd51, 7'd54, 7'd55, 7'd58,
        7'd59, 7'd62, 7'd63, 7'd66, 7'd67, 7'd70, 7'd71
    };

    localparam logic [6:0] TYPE_DEFAULT = 7'h02;
    localparam logic [6:0] TYPE_FLOAT3  = 7'h32;
    localparam logic [6:0] TYPE_FLOAT4  = 7'h42;
    localparam logic [6:0] TYPE_COLOR   = 7'h40;
    localparam logic [7:0] BLEND_OFFSET = 8'h0c;

    localparam logic [2:0] POS_NONE   = 3'd0;
    localparam logic [2:0] POS_XYZRHW = 3'd2;
    localparam logic [2:0] POS_BLEND1 = 3'd3;

    localparam logic [2:0] TEX_SET_LAST = 3'd7;

    typedef struct packed {
        logic        reject;
        logic [11:0] flags_word;
        logic [31:0] tex_sizes;
        logic [6:0]  elem0_type;
        logic        blend;
        logic [6:0]  blend_type;
        logic        normal;
        logic        diffuse;
        logic        specular;
        logic [7:0]  normal_off;
        logic [7:0]  diffuse_off;
        logic [7:0]  specular_off;
        logic [7:0]  tex_off;
        logic [3:0]  ntex;
        logic [15:0] codes;
        logic [4:0]  last_slot;
    } desc_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } desc_push_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } desc_head_t;

    function automatic logic [2:0] tex_size(input logic [1:0] code);
        logic [2:0] sz;
        case (code)
            2'd0:    sz = 3'd2;
            2'd1:    sz = 3'd3;
            2'd2:    sz = 3'd4;
            default: sz = 3'd1;
        endcase
        return sz;
    endfunction

endpackage

>>> hdl/vfld_in_if.sv
// Input channel of the decoder: one format word per item.
// Standalone interface, no dependencies.
interface vfld_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] format_word;

    modport source (output valid, output format_word, input ready);
    modport sink   (input valid, input format_word, output ready);
endinterface

>>> hdl/vfld_out_if.sv
// Output channel of the decoder: one declaration word per item.
// Standalone interface, no dependencies.
interface vfld_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [6:0]  word_index;
    logic [31:0] word_value;
    logic        last;

    modport source (output valid, output accepted, output word_index, output word_value,
                    output last, input ready);
    modport sink   (input valid, input accepted, input word_index, input word_value,
                    input last, output ready);
endinterface

>>> hdl/vfld_front.sv
// Front end: accepts format words and decodes them into layout descriptors.
// Depends on vfld_pkg and vfld_in_if.
module vfld_front (
    vfld_in_if.sink            format_ch,
    input  logic               full,
    output vfld_pkg::desc_push_t push
);
    import vfld_pkg::*;

    logic [31:0] fw;
    logic [2:0]  code;
    logic        rhw;
    logic        blend;
    logic [2:0]  nblend;
    logic [7:0]  p0;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [7:0]  p3;
    logic [3:0]  ntex;
    desc_t       d;

    assign fw     = format_ch.format_word;
    assign code   = fw[3:1];
    assign rhw    = (code == POS_XYZRHW);
    assign blend  = (code >= POS_BLEND1);
    assign nblend = code - 3'd2;
    assign ntex   = fw[11:8];

    always_comb
    begin
        if (code == POS_NONE)
        begin
            p0 = 8'd0;
        end
        else if (rhw)
        begin
            p0 = 8'd16;
        end
        else if (blend)
        begin
            p0 = 8'd12 + {3'b000, nblend, 2'b00};
        end
        else
        begin
            p0 = 8'd12;
        end
    end

    assign p1 = p0 + (fw[4] ? 8'd12 : 8'd0);
    assign p2 = p1 + (fw[6] ? 8'd4 : 8'd0);
    assign p3 = p2 + (fw[7] ? 8'd4 : 8'd0);

    always_comb
    begin
        d              = '0;
        d.reject       = (ntex > 4'(MAX_TEX_SETS));
        d.flags_word   = {fw[7], fw[6], 8'h00, rhw, 1'b0};
        for (int i = 0; i < 4; i++)
        begin
            d.tex_sizes[8*i +: 8] = (4'(i) < ntex) ? {5'b00000, tex_size(fw[16+2*i +: 2])}
                                                   : 8'h00;
        end
        d.elem0_type   = rhw ? TYPE_FLOAT4 : ((code != POS_NONE) ? TYPE_FLOAT3 : TYPE_DEFAULT);
        d.blend        = blend;
        d.blend_type   = {nblend, 4'h2};
        d.normal       = fw[4];
        d.diffuse      = fw[6];
        d.specular     = fw[7];
        d.normal_off   = p0;
        d.diffuse_off  = p1;
        d.specular_off = p2;
        d.tex_off      = p3;
        d.ntex         = ntex;
        d.codes        = fw[31:16];
        d.last_slot    = (ntex > 4'(TEX_SET_LAST)) ? SLOT_TEX_LAST : SLOT_ELEM_LAST;
    end

    assign format_ch.ready = !full;
    assign push            = '{valid: format_ch.valid && !full, desc: d};

endmodule

>>> hdl/vfld_queue.sv
// Two-entry descriptor queue between the front end and the back end.
// Depends on vfld_pkg.
module vfld_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vfld_pkg::desc_push_t push,
    output logic                 full,
    output vfld_pkg::desc_head_t head,
    input  logic                 pop
);
    import vfld_pkg::*;

    desc_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign head      = '{valid: (count_reg != 2'd0), desc: mem_reg[rd_ptr_reg]};
    assign do_pop    = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.desc;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/vfld_back.sv
// Back end: walks the declaration word slots of one descriptor and emits items.
// Depends on vfld_pkg and vfld_out_if.
module vfld_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vfld_pkg::desc_head_t head,
    output logic                 pop,
    vfld_out_if.source           decl_ch
);
    import vfld_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    desc_t       desc_reg;
    desc_t       desc_next;
    logic [4:0]  slot_reg;
    logic [4:0]  slot_next;
    logic [7:0]  run_reg;
    logic [7:0]  run_next;
    logic [15:0] codes_reg;
    logic [15:0] codes_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        accepted_reg;
    logic        accepted_next;
    logic [6:0]  word_index_reg;
    logic [6:0]  word_index_next;
    logic [31:0] word_value_reg;
    logic [31:0] word_value_next;
    logic        last_reg;
    logic        last_next;

    logic        out_free;
    logic        hit;
    logic [31:0] value;
    logic [4:0]  tex_slot;
    logic [2:0]  tex_set;
    logic        tex_active;
    logic [2:0]  sz;
    logic [6:0]  tex_type;

    assign out_free   = !out_valid_reg || decl_ch.ready;
    assign tex_slot   = slot_reg - SLOT_TEX_FIRST;
    assign tex_set    = tex_slot[3:1];
    assign tex_active = ({1'b0, tex_set} < desc_reg.ntex);
    assign sz         = tex_size(codes_reg[1:0]);
    assign tex_type   = {sz, 4'h2};

    always_comb
    begin
        hit   = 1'b1;
        value = 32'(TYPE_DEFAULT);
        case (slot_reg)
            SLOT_FLAGS:      value = 32'(desc_reg.flags_word);
            SLOT_TEX_SIZES:  value = desc_reg.tex_sizes;
            SLOT_ELEM0:      value = 32'(desc_reg.elem0_type);
            SLOT_BLEND_OFF:
            begin
                hit   = desc_reg.blend;
                value = 32'(BLEND_OFFSET);
            end
            SLOT_BLEND_TYPE: value = 32'(desc_reg.blend ? desc_reg.blend_type : TYPE_DEFAULT);
            SLOT_NORM_OFF:
            begin
                hit   = desc_reg.normal;
                value = 32'(desc_reg.normal_off);
            end
            SLOT_NORM_TYPE:  value = 32'(desc_reg.normal ? TYPE_FLOAT3 : TYPE_DEFAULT);
            SLOT_DIFF_OFF:
            begin
                hit   = desc_reg.diffuse;
                value = 32'(desc_reg.diffuse_off);
            end
            SLOT_DIFF_TYPE:  value = 32'(desc_reg.diffuse ? TYPE_COLOR : TYPE_DEFAULT);
            SLOT_SPEC_OFF:
            begin
                hit   = desc_reg.specular;
                value = 32'(desc_reg.specular_off);
            end
            SLOT_SPEC_TYPE:  value = 32'(desc_reg.specular ? TYPE_COLOR : TYPE_DEFAULT);
            SLOT_ELEM5, SLOT_ELEM6, SLOT_ELEM7, SLOT_ELEM8:
            begin
                value = 32'(TYPE_DEFAULT);
            end
            default:
            begin
                if (!tex_slot[0])
                begin
                    hit   = tex_active;
                    value = 32'(run_reg);
                end
                else
                begin
                    hit   = tex_active || (tex_set != TEX_SET_LAST);
                    value = 32'(tex_active ? tex_type : TYPE_DEFAULT);
                end
            end
        endcase
    end

    assign pop = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        desc_next       = desc_reg;
        slot_next       = slot_reg;
        run_next        = run_reg;
        codes_next      = codes_reg;
        out_valid_next  = out_valid_reg && !decl_ch.ready;
        accepted_next   = accepted_reg;
        word_index_next = word_index_reg;
        word_value_next = word_value_reg;
        last_next       = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    desc_next  = head.desc;
                    slot_next  = SLOT_FLAGS;
                    run_next   = head.desc.tex_off;
                    codes_next = head.desc.codes;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    if (desc_reg.reject)
                    begin
                        out_valid_next  = 1'b1;
                        accepted_next   = 1'b0;
                        word_index_next = 7'd0;
                        word_value_next = 32'd0;
                        last_next       = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        if (hit)
                        begin
                            out_valid_next  = 1'b1;
                            accepted_next   = 1'b1;
                            word_index_next = SLOT_WORD[slot_reg];
                            word_value_next = value;
                            last_next       = (slot_reg == desc_reg.last_slot);
                        end
                        if ((slot_reg >= SLOT_TEX_FIRST) && tex_slot[0])
                        begin
                            run_next   = run_reg + {3'b000, sz, 2'b00};
                            codes_next = {2'b00, codes_reg[15:2]};
                        end
                        if (slot_reg == desc_reg.last_slot)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            slot_next = slot_reg + 5'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg       <= desc_next;
        slot_reg       <= slot_next;
        run_reg        <= run_next;
        codes_reg      <= codes_next;
        accepted_reg   <= accepted_next;
        word_index_reg <= word_index_next;
        word_value_reg <= word_value_next;
        last_reg       <= last_next;
    end

    assign decl_ch.valid      = out_valid_reg;
    assign decl_ch.accepted   = accepted_reg;
    assign decl_ch.word_index = word_index_reg;
    assign decl_ch.word_value = word_value_reg;
    assign decl_ch.last       = last_reg;

    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !accepted_reg |-> last_reg && (word_index_reg == 7'd0))
        else $error("rejected item must be a single last item at index zero");

    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && accepted_reg && last_reg |->
            (word_index_reg == WORD_ELEM_LAST) || (word_index_reg == WORD_TEX_TYPE_LAST))
        else $error("final declaration word has wrong index");

    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && decl_ch.ready && !last_reg |=>
            !out_valid_reg || (word_index_reg > $past(word_index_reg)))
        else $error("declaration words not in ascending order");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && !desc_reg.reject |-> slot_reg <= desc_reg.last_slot)
        else $error("slot walk ran past its final slot");

endmodule

>>> hdl/vertex_format_layout_decoder_unit.sv
// Vertex format layout decoder, top level.
// Depends on vfld_pkg, vfld_in_if, vfld_out_if, vfld_front, vfld_queue, vfld_back.
//
// format_ch carries one 32-bit format word per item. decl_ch returns, per
// format word, the declaration words it writes in ascending index order, each
// with its final value and last set on the final one. A format word whose
// texture count exceeds the limit yields one item with accepted low.
// The front end decodes a format word in the cycle it is accepted and pushes
// the descriptor into a two-entry queue. The back end takes one descriptor,
// then walks 29 word slots (31 with eight texture sets), one slot per cycle
// while decl_ch does not stall; a rejected descriptor yields one item and
// skips the walk. The first item passes the queue entry, the back end
// descriptor register and the output register; the slot walk sets throughput.
// When decl_ch stalls, the output register holds its item and the walk
// pauses; the queue then fills and format_ch.ready drops once both entries
// are in use.
// Reset empties the queue, idles the back end and clears decl_ch.valid.
module vertex_format_layout_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    vfld_in_if.sink    format_ch,
    vfld_out_if.source decl_ch
);
    import vfld_pkg::*;

    desc_push_t push;
    desc_head_t head;
    logic       full;
    logic       pop;

    vfld_front u_front (
        .format_ch (format_ch),
        .full      (full),
        .push      (push)
    );

    vfld_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    vfld_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .decl_ch (decl_ch)
    );

endmodule
